FILE: rtl/s2d_pkg.sv
// s2d_pkg: shared types and constants for the signed 64-bit to decimal ASCII converter.
// No dependencies; used by every module under rtl/.
package s2d_pkg;

  localparam int VALUE_W     = 64;
  localparam int CHAR_W      = 8;
  // Magnitude never exceeds 2^63, which has 19 decimal digits.
  localparam int NUM_DIGITS  = 19;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int STEP_BITS   = 4;
  localparam int CONV_STEPS  = VALUE_W / STEP_BITS;
  localparam int CONV_CNT_W  = $clog2(CONV_STEPS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  // One classified value waiting for conversion.
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } s2d_item_t;

  // Queue handshake seen by the back end.
  typedef struct packed {
    logic      avail;
    s2d_item_t item;
  } s2d_head_t;

endpackage

FILE: rtl/s2d_front.sv
// s2d_front: accepts input transactions, splits sign and unsigned magnitude.
// Depends on s2d_pkg; feeds s2d_queue.
module s2d_front (
  input  logic                              valid,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  output logic                              stall,
  input  logic                              queue_full,
  output logic                              push,
  output s2d_pkg::s2d_item_t                item
);

  logic [s2d_pkg::VALUE_W-1:0] raw;

  assign raw   = value;
  assign stall = queue_full;
  assign push  = valid && !queue_full;

  // Two's complement negate also maps the most negative value to 2^63.
  always_comb begin
    item.neg = raw[s2d_pkg::VALUE_W-1];
    item.mag = item.neg ? (~raw + 64'd1) : raw;
  end

endmodule

FILE: rtl/s2d_queue.sv
// s2d_queue: small register FIFO between the front and back ends.
// Depends on s2d_pkg for the item type.
module s2d_queue #(
  parameter int DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  s2d_pkg::s2d_item_t push_item,
  output logic               full,
  input  logic               pop,
  output s2d_pkg::s2d_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  s2d_pkg::s2d_item_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full       = (count == FULL_CNT);
  assign head.avail = (count != '0);
  assign head.item  = entries[rd_ptr];
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/s2d_back.sv
// s2d_back: double-dabble binary to BCD, four bits per cycle, then emits ASCII.
// Depends on s2d_pkg; pulls from s2d_queue and drives the output register.
module s2d_back (
  input  logic                           clk,
  input  logic                           rst,
  input  s2d_pkg::s2d_head_t             head,
  output logic                           pop,
  output logic                           char_valid,
  input  logic                           char_stall,
  output logic [s2d_pkg::CHAR_W-1:0]     character,
  output logic                           last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                             state;
  logic                               neg;
  logic [s2d_pkg::VALUE_W-1:0]        mag;
  logic [s2d_pkg::BCD_W-1:0]          bcd;
  logic [s2d_pkg::BCD_W-1:0]          bcd_next;
  logic [s2d_pkg::CONV_CNT_W-1:0]     step;
  logic [s2d_pkg::DIGIT_IDX_W-1:0]    idx;
  logic [s2d_pkg::DIGIT_IDX_W-1:0]    top_idx;
  logic [3:0]                         cur_digit;
  logic                               out_free;
  logic                               emit;

  localparam logic [s2d_pkg::CONV_CNT_W-1:0] LAST_STEP =
    s2d_pkg::CONV_CNT_W'(s2d_pkg::CONV_STEPS - 1);

  // One shift-and-add-3 step.
  function automatic logic [s2d_pkg::BCD_W-1:0] dabble(
    input logic [s2d_pkg::BCD_W-1:0] b,
    input logic                      bit_in
  );
    logic [s2d_pkg::BCD_W-1:0] t;
    t = b;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (t[4*i +: 4] >= 4'd5) begin
        t[4*i +: 4] = t[4*i +: 4] + 4'd3;
      end
    end
    return {t[s2d_pkg::BCD_W-2:0], bit_in};
  endfunction

  always_comb begin
    bcd_next = bcd;
    for (int s = 0; s < s2d_pkg::STEP_BITS; s++) begin
      bcd_next = dabble(bcd_next, mag[s2d_pkg::VALUE_W-1-s]);
    end
  end

  // Highest nonzero digit; zero value falls back to digit 0.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        top_idx = s2d_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[4*idx +: 4];
  assign out_free  = !char_valid || !char_stall;
  assign emit      = out_free && ((state == ST_SIGN) || (state == ST_DIGIT));
  assign pop       = (state == ST_IDLE) && head.avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
      step       <= '0;
      idx        <= '0;
    end else begin
      if (emit) begin
        char_valid <= 1'b1;
      end else if (!char_stall) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.avail) begin
            neg   <= head.item.neg;
            mag   <= head.item.mag;
            bcd   <= '0;
            step  <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd  <= bcd_next;
          mag  <= {mag[s2d_pkg::VALUE_W-1-s2d_pkg::STEP_BITS:0],
                   {s2d_pkg::STEP_BITS{1'b0}}};
          step <= step + 1'b1;
          if (step == LAST_STEP) begin
            state <= ST_FIND;
          end
        end
        ST_FIND: begin
          idx   <= top_idx;
          state <= neg ? ST_SIGN : ST_DIGIT;
        end
        ST_SIGN: begin
          if (out_free) begin
            character  <= s2d_pkg::CH_MINUS;
            last       <= 1'b0;
            state      <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            character  <= s2d_pkg::CH_ZERO + {4'd0, cur_digit};
            last       <= (idx == '0);
            if (idx == '0) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/signed_int64_to_decimal_ascii.sv
// signed_int64_to_decimal_ascii: signed 64-bit integer to decimal ASCII, one char per cycle when unstalled.
// Per value: a dequeue state, conversion at four bits per cycle through the
// double-dabble unit, a digit-search state, then 1 to 20 characters at one per
// cycle while char_stall is low.
// A 2-entry queue lets the next value be accepted while the current one converts.
// Synchronous active-high reset empties the queue and the output register.
module signed_int64_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               value_valid,
  output logic                               value_stall,
  input  logic signed [s2d_pkg::VALUE_W-1:0] value,
  output logic                               char_valid,
  input  logic                               char_stall,
  output logic [s2d_pkg::CHAR_W-1:0]         character,
  output logic                               last
);

  logic               queue_full;
  logic               push;
  logic               pop;
  s2d_pkg::s2d_item_t push_item;
  s2d_pkg::s2d_head_t head;

  s2d_front u_front (
    .valid      (value_valid),
    .value      (value),
    .stall      (value_stall),
    .queue_full (queue_full),
    .push       (push),
    .item       (push_item)
  );

  s2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .head      (head)
  );

  s2d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for signed_int64_to_decimal_ascii.
// Drives signed 64-bit values, predicts their decimal text and checks every character.
// Depends on rtl/s2d_pkg.sv and rtl/signed_int64_to_decimal_ascii.sv.
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 45;   // longest per-value latency plus margin
  localparam int PHASE_ITEMS  = 55;
  localparam int SQUEEZE_ITEMS = 16;

  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] character;
    logic                       last;
  } ascii_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               value_valid = 1'b0;
  logic                               value_stall;
  logic signed [s2d_pkg::VALUE_W-1:0] value = '0;
  logic                               char_valid;
  logic                               char_stall = 1'b0;
  logic [s2d_pkg::CHAR_W-1:0]         character;
  logic                               last;

  logic signed [s2d_pkg::VALUE_W-1:0] pending_values [$];
  ascii_char_t                        expected_text [$];
  ascii_char_t                        oldest_char;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_arm      = 1'b0;
  int          hold_left     = 0;

  int mismatches      = 0;
  int values_accepted = 0;
  int negatives_seen  = 0;
  int chars_checked   = 0;
  int longest_text    = 0;
  int text_len;

  signed_int64_to_decimal_ascii u_dut (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .character   (character),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Appends the decimal text of v to the expected characters; returns its length.
  function automatic int predict_decimal_text(
    input logic signed [s2d_pkg::VALUE_W-1:0] v
  );
    logic [s2d_pkg::VALUE_W-1:0] mag;
    logic [3:0]                  digs [0:19];
    int                          n;
    ascii_char_t                 c;
    mag = v;
    if (v[s2d_pkg::VALUE_W-1]) mag = ~mag + 64'd1;  // most negative value stays 2^63 unsigned
    n = 0;
    do begin
      digs[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (v[s2d_pkg::VALUE_W-1]) begin
      c.character = s2d_pkg::CH_MINUS;
      c.last      = 1'b0;
      expected_text.push_back(c);
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.character = s2d_pkg::CH_ZERO + digs[k];
      c.last      = (k == 0);
      expected_text.push_back(c);
    end
    return n + (v[s2d_pkg::VALUE_W-1] ? 1 : 0);
  endfunction

  // Driver: offers the next pending value once the current transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
      value       <= '0;
    end else begin
      if (value_valid && !value_stall) begin
        text_len = predict_decimal_text(value);
        if (text_len > longest_text) longest_text = text_len;
        if (value[s2d_pkg::VALUE_W-1]) negatives_seen++;
        values_accepted++;
      end
      if (!value_valid || !value_stall) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          value       <= pending_values.pop_front();
          value_valid <= 1'b1;
        end else begin
          value_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the monitor only sees a level.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_arm) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: checks each accepted character against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected character %0d last %0b with nothing pending",
                     $time, character, last);
        end else begin
          oldest_char = expected_text.pop_front();
          if (character !== oldest_char.character || last !== oldest_char.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: expected char %0d last %0b, got char %0d last %0b",
                       $time, oldest_char.character, oldest_char.last, character, last);
          end
        end
      end
      char_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    logic signed [s2d_pkg::VALUE_W-1:0] directed [$];
    logic signed [s2d_pkg::VALUE_W-1:0] rnd_value;
    logic [s2d_pkg::VALUE_W-1:0]        raw;
    logic [s2d_pkg::VALUE_W-1:0]        mag;
    logic [s2d_pkg::VALUE_W-1:0]        lim;
    int unsigned                        sel;
    int unsigned                        idle_send [0:4];
    int unsigned                        idle_recv [0:4];

    directed = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, 64'sd99, -64'sd100,
                 64'sd12345, 64'sd4294967295, -64'sd4294967296,
                 64'sd999999999999999999, 64'sd1000000000000000000,
                 -64'sd1000000000000000000, 64'sd1234567890123456789,
                 64'sd9223372036854775807, 64'sd9223372036854775806,
                 -64'sd9223372036854775807, 64'sh8000_0000_0000_0000,
                 64'sh5555_5555_5555_5555, 64'shAAAA_AAAA_AAAA_AAAA, 64'sd7};
    // phase 0 squeezes the block with a long receiver hold-off
    idle_send = '{0, 0, 82, 0, 31};
    idle_recv = '{0, 0, 0, 82, 31};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    foreach (directed[i]) pending_values.push_back(directed[i]);
    while (pending_values.size() != 0 || value_valid) @(negedge clk);
    while (expected_text.size() != 0) @(negedge clk);

    for (int ph = 0; ph < 5; ph++) begin
      @(negedge clk);
      send_idle_pct = idle_send[ph];
      stall_pct     = idle_recv[ph];
      if (ph == 0) hold_arm <= 1'b1;
      for (int i = 0; i < (ph == 0 ? SQUEEZE_ITEMS : PHASE_ITEMS); i++) begin
        raw = {$urandom, $urandom};
        sel = $urandom_range(9);
        if (sel < 2) begin
          rnd_value = raw;  // full width, all bits toggle
        end else if (sel == 2) begin
          rnd_value = $urandom_range(1) ? 64'sh8000_0000_0000_0000
                                        : 64'sh7FFF_FFFF_FFFF_FFFF;
        end else begin
          lim = 64'd1;
          repeat ($urandom_range(19, 1)) lim = lim * 10;
          // around a power of ten, else uniform below it
          if (sel == 3) mag = lim - 64'd1 + $urandom_range(2);
          else mag = raw % lim;
          rnd_value = $urandom_range(1) ? -mag : mag;
        end
        pending_values.push_back(rnd_value);
      end
      if (ph == 0) begin
        @(negedge clk);
        hold_arm <= 1'b0;
      end
      while (pending_values.size() != 0 || value_valid) @(negedge clk);
      // sender stays quiet until the block has drained
      while (expected_text.size() != 0) @(negedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("converted %0d values (%0d negative), checked %0d characters, longest text %0d",
             values_accepted, negatives_seen, chars_checked, longest_text);
    $display("idle mixes: none, sender, receiver, both, plus a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d characters still expected", mismatches,
               expected_text.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d characters still expected", expected_text.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
